>>> design/plam_pkg.sv
`default_nettype none
package plam_pkg;

	localparam int MaxPoints = 64;
	localparam int AddrW     = $clog2(MaxPoints);
	localparam int CountW    = 7;
	localparam int CoordW    = 24;
	localparam int DiffW     = CoordW + 1;
	localparam int MagW      = CoordW;
	localparam int LenW      = 25;
	localparam int SqW       = 50;
	localparam int ProdW     = 50;
	localparam int QuotW     = 26;
	localparam int SpanW     = 32;
	localparam int SumW      = 28;

	localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
	localparam logic signed [CoordW-1:0] CoordMin = -24'sh800000;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic                     mode;
		logic [5:0]               vertex_index;
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic signed [CoordW-1:0] vertex_z;
		logic signed [CoordW-1:0] query_along;
		logic signed [CoordW-1:0] query_across;
	} in_item_t;

	typedef struct packed {
		logic signed [CoordW-1:0] mapped_x;
		logic signed [CoordW-1:0] mapped_y;
		logic signed [CoordW-1:0] mapped_z;
		logic                     on_ribbon;
	} out_item_t;

	localparam logic ModeWrite = 1'b0;
	localparam logic ModeQuery = 1'b1;

	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
		logic signed [CoordW-1:0] r;
		if (v > SumW'(CoordMax))
			r = CoordMax;
		else if (v < SumW'(CoordMin))
			r = CoordMin;
		else
			r = v[CoordW-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/plam_vstore.sv
`default_nettype none
module plam_vstore import plam_pkg::*; (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire vertex_t          wdata,
	input  wire logic [AddrW-1:0] raddr_a,
	input  wire logic [AddrW-1:0] raddr_b,
	output vertex_t               rdata_a,
	output vertex_t               rdata_b
);

	vertex_t mem [MaxPoints];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

>>> design/polyline_arc_length_mapper_core.sv
// Polyline arc-length mapper. Vertex writes are stored while idle. A query walks the
// segments one at a time through a single shared 25x25 multiplier, a bit-pair square
// root and a one-bit-a-cycle divider: each segment visited goes through fetch,
// difference, three squares, 25 root steps and a span check, and the hit segment then
// takes three multiply-round-divide passes. At most 63 segments are visited, and
// in_ready is low for the whole query. The result sits in an output register, so
// the next request can be accepted while it waits.
`default_nettype none
module polyline_arc_length_mapper_core import plam_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_item_t              out_data,
	input  wire logic              cfg_we,
	input  wire logic [CountW-1:0] cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_FETCH = 11'b00000000010,
		S_DIFF  = 11'b00000000100,
		S_SQ    = 11'b00000001000,
		S_SQRT  = 11'b00000010000,
		S_CHECK = 11'b00000100000,
		S_MUL   = 11'b00001000000,
		S_RND   = 11'b00010000000,
		S_DIV   = 11'b00100000000,
		S_ADD   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [CountW-1:0]        vcount_q;
	logic [CountW-1:0]        nseg_q;
	logic [AddrW-1:0]         seg_q;
	logic signed [CoordW-1:0] along_q, across_q;
	logic [SpanW-1:0]         start_q;
	logic signed [DiffW-1:0]  d_q [3];
	logic [SqW-1:0]           acc_q, res_q, bit_q;
	logic [ProdW-1:0]         prod_q;
	logic [4:0]               cnt_q;
	logic [1:0]               j_q;
	logic [LenW-1:0]          off_q;
	logic [LenW-1:0]          rem_q;
	logic [QuotW-1:0]         dq_q;
	logic signed [CoordW-1:0] pt_q [3];
	logic                     on_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	vertex_t va, vb;
	vertex_t wr_vtx;
	logic    wr_en;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign wr_vtx    = {in_data.vertex_x, in_data.vertex_y, in_data.vertex_z};
	assign wr_en     = in_valid && in_ready && (in_data.mode == ModeWrite)
		&& ({1'b0, in_data.vertex_index} < CountW'(MaxPoints));

	plam_vstore u_vstore (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (in_data.vertex_index[AddrW-1:0]),
		.wdata   (wr_vtx),
		.raddr_a (seg_q),
		.raddr_b (seg_q + AddrW'(1)),
		.rdata_a (va),
		.rdata_b (vb)
	);

	// shared multiplier operands
	logic [1:0]              dsel;
	logic signed [DiffW-1:0] dcur;
	logic [MagW-1:0]         dmag;
	logic [LenW-1:0]         mul_b;
	logic [ProdW-1:0]        mul_p;

	always_comb begin
		dsel  = (state_q == S_SQ) ? cnt_q[1:0] : j_q;
		if (dsel == 2'd3)
			dsel = 2'd2;
		dcur  = d_q[dsel];
		dmag  = dcur[DiffW-1] ? MagW'(-dcur) : MagW'(dcur);
		mul_b = (state_q == S_SQ) ? LenW'(dmag) : off_q;
		mul_p = ProdW'(LenW'(dmag)) * ProdW'(mul_b);
	end

	logic [CountW-1:0]          ccount;
	logic [LenW-1:0]            len;
	logic [SpanW-1:0]           span_end;
	logic signed [SpanW:0]      q_ext;
	logic                       hit;
	logic [SqW:0]               sq_try;
	logic [ProdW:0]             num;
	logic [LenW:0]              dv_try;
	logic signed [QuotW:0]      qsig;
	logic signed [CoordW-1:0]   p1;
	logic signed [SumW-1:0]     coord_sum;

	always_comb begin
		ccount = vcount_q;
		if (ccount > CountW'(MaxPoints))
			ccount = CountW'(MaxPoints);
		if (ccount < CountW'(2))
			ccount = CountW'(2);
		len      = res_q[LenW-1:0];
		span_end = start_q + SpanW'(len);
		q_ext    = (SpanW+1)'(along_q);
		hit      = (q_ext >= $signed({1'b0, start_q})) && (q_ext < $signed({1'b0, span_end}));
		sq_try   = (SqW+1)'(res_q) + (SqW+1)'(bit_q);
		num      = (ProdW+1)'(prod_q) + (ProdW+1)'(len >> 1);
		dv_try   = {rem_q, dq_q[QuotW-1]};
		qsig     = d_q[j_q == 2'd3 ? 2'd2 : j_q][DiffW-1]
			? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		case (j_q)
			2'd0:    p1 = va.x;
			2'd1:    p1 = va.y;
			default: p1 = va.z;
		endcase
		coord_sum = SumW'(p1) + SumW'(qsig) + ((j_q == 2'd1) ? SumW'(across_q) : SumW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= CountW'(MaxPoints);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				vcount_q <= cfg_data;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_data.mode == ModeQuery)
					state_q <= S_FETCH;
				S_FETCH: state_q <= S_DIFF;
				S_DIFF:  state_q <= S_SQ;
				S_SQ:    if (cnt_q == 5'd3)
					state_q <= S_SQRT;
				S_SQRT:  if (bit_q == SqW'(1))
					state_q <= S_CHECK;
				S_CHECK: begin
					if (hit)
						state_q <= S_MUL;
					else if (CountW'(seg_q) + CountW'(1) == nseg_q)
						state_q <= S_OUT;
					else
						state_q <= S_FETCH;
				end
				S_MUL:   state_q <= S_RND;
				S_RND:   state_q <= S_DIV;
				S_DIV:   if (cnt_q == 5'(QuotW - 1))
					state_q <= S_ADD;
				S_ADD:   state_q <= (j_q == 2'd2) ? S_OUT : S_MUL;
				S_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				along_q  <= in_data.query_along;
				across_q <= in_data.query_across;
				nseg_q   <= ccount - CountW'(1);
				seg_q    <= '0;
				start_q  <= '0;
			end
			S_DIFF: begin
				d_q[0] <= DiffW'(vb.x) - DiffW'(va.x);
				d_q[1] <= DiffW'(vb.y) - DiffW'(va.y);
				d_q[2] <= DiffW'(vb.z) - DiffW'(va.z);
				acc_q  <= '0;
				res_q  <= '0;
				bit_q  <= SqW'(1) << 48;
				cnt_q  <= '0;
			end
			S_SQ: begin
				// product is registered and added to the accumulator in the next cycle
				prod_q <= mul_p;
				if (cnt_q != 5'd0)
					acc_q <= acc_q + prod_q;
				cnt_q <= cnt_q + 5'd1;
			end
			S_SQRT: begin
				if ((SqW+1)'(acc_q) >= sq_try) begin
					acc_q <= acc_q - sq_try[SqW-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_CHECK: begin
				off_q <= LenW'(q_ext - $signed({1'b0, start_q}));
				j_q   <= 2'd0;
				on_q  <= hit;
				if (!hit) begin
					start_q  <= span_end;
					seg_q    <= seg_q + AddrW'(1);
					pt_q[0]  <= '0;
					pt_q[1]  <= '0;
					pt_q[2]  <= '0;
				end
			end
			S_MUL: prod_q <= mul_p;
			S_RND: begin
				rem_q <= LenW'(num >> QuotW);
				dq_q  <= num[QuotW-1:0];
				cnt_q <= '0;
			end
			S_DIV: begin
				if (dv_try >= (LenW+1)'(len)) begin
					rem_q <= LenW'(dv_try - (LenW+1)'(len));
					dq_q  <= {dq_q[QuotW-2:0], 1'b1};
				end else begin
					rem_q <= dv_try[LenW-1:0];
					dq_q  <= {dq_q[QuotW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			S_ADD: begin
				pt_q[j_q == 2'd3 ? 2'd2 : j_q] <= sat_coord(coord_sum);
				j_q <= j_q + 2'd1;
			end
			S_OUT: if (!out_valid_q || out_ready) begin
				out_q.mapped_x  <= pt_q[0];
				out_q.mapped_y  <= pt_q[1];
				out_q.mapped_z  <= pt_q[2];
				out_q.on_ribbon <= on_q;
			end
			default: ;
		endcase
	end

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && !out_ready) |=> state_q == S_OUT)
		else $error("finished result dropped while output held");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> rem_q < len)
		else $error("divider remainder not below segment length");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.on_ribbon) |->
		(out_q.mapped_x == '0 && out_q.mapped_y == '0 && out_q.mapped_z == '0))
		else $error("off-line result carries non-zero coordinates");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.mode == ModeQuery) |=> !in_ready)
		else $error("request taken during a query");

endmodule
`default_nettype wire
